// ===== design/ple_pkg.sv =====
// shared types, widths and codes for the positional list engine
// no dependencies; imported by every module of the block

package ple_pkg;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 9;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 3;
    localparam int LEN_W       = 9;
    localparam int DEPTH_DEF   = 256;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_GET    = 3'd3,
        KIND_LOCATE = 3'd4,
        KIND_PRED   = 3'd5,
        KIND_SUCC   = 3'd6
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_BADPOS     = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NOTFOUND   = 3'd3,
        ST_NONEIGHBOR = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    // address taken relative to the index register
    typedef enum logic [1:0] {
        ADR_IDX,
        ADR_IDX_M1,
        ADR_IDX_P1
    } t_adr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic     load;
        t_idx_op  idx_op;
        logic     rd_en;
        t_adr_sel rd_sel;
        logic     wr_en;
        t_adr_sel wr_sel;
        logic     wr_value;
        t_cnt_op  cnt_op;
        logic     set_status;
        t_status  status;
        logic     cap_elem;
        logic     cap_found;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  pos_bad_ins;
        logic  pos_bad;
        logic  count_zero;
        logic  count_one;
        logic  count_full;
        logic  idx_ge_pos;
        logic  idx_lt_count;
        logic  idx_zero;
        logic  idx_last;
        logic  match;
        logic  out_free;
    } t_flags;

endpackage

// ===== design/positional_list_engine.sv =====
// top level of the positional list engine: stream ports, sequencer and datapath
// depends on ple_pkg, ple_ctrl and ple_datapath

// Bounded ordered list of signed 32-bit elements kept in a store of DEPTH
// entries with an element count. Every request transfer on the slave stream
// gives exactly one result transfer on the master stream. The request kind travels
// in s_axis_tuser: clear, insert at a 1-based position, delete at a position, get
// at a position, locate the first position of a value, or predecessor / successor
// of the first occurrence of a value; an unused kind changes nothing and returns
// ok. The result carries a status, the element fetched, removed or found as a
// neighbor (zero otherwise), the position found by locate (zero otherwise), the
// length after the request and an empty flag. A full list rejects inserts with
// status full, though a bad position is reported first. One request is worked
// on at a time. Insert moves entries up one at a time (count - position + 1
// entries) and delete moves entries down; locate, predecessor and successor
// scan entries up to the first match. The sequencer makes one store access at a
// time with a registered read, and checks the index once per entry moved. The
// longest request at the default depth is a delete at position 1 of a full list.
// A finished result sits in an output register, so the next request is taken
// while it waits; a new result is only stored once the old one has been
// transferred. The length field is 9 bits, so with DEPTH above 256 it shows the
// count modulo 512.

module positional_list_engine import ple_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [8:0] position, [40:9] value, [47:41] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] kind
    input  logic [KIND_W-1:0]      s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] status, [34:3] element_out, [43:35] found_position,
    // [52:44] length, [53] is_empty, [55:54] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cmd   w_cmd;
    t_flags w_flags;

    // sequencer: accepts a request, walks the store, hands the result over
    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    // store, count, index and the output register
    ple_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_flags    (w_flags),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ===== design/ple_datapath.sv =====
// element store, count, index and result registers of the positional list engine
// depends on ple_pkg; driven by ple_ctrl through t_cmd, reports through t_flags

module ple_datapath import ple_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [KIND_W-1:0]      i_s_tuser,
    input  t_cmd                   i_cmd,
    output t_flags                 o_flags,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0]       r_mem [DEPTH];
    logic [VAL_W-1:0]       r_rdata;
    t_kind                  r_kind;
    logic [POS_W-1:0]       r_pos;
    logic [VAL_W-1:0]       r_value;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          n_idx;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    t_status                r_status;
    logic [VAL_W-1:0]       r_elem;
    logic [POS_W-1:0]       r_found;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CW-1:0] w_idx_m1;
    logic [CW-1:0] w_idx_p1;
    logic [CW-1:0] w_rd_idx;
    logic [CW-1:0] w_wr_idx;
    logic [EW-1:0] w_pos_x;
    logic [EW-1:0] w_cnt_x;
    logic [EW-1:0] w_idx_x;

    assign w_idx_m1 = r_idx - CW'(1);
    assign w_idx_p1 = r_idx + CW'(1);
    assign w_pos_x  = EW'(r_pos);
    assign w_cnt_x  = EW'(r_count);
    assign w_idx_x  = EW'(r_idx);

    always_comb begin
        unique case (i_cmd.rd_sel)
            ADR_IDX_M1: w_rd_idx = w_idx_m1;
            ADR_IDX_P1: w_rd_idx = w_idx_p1;
            default:    w_rd_idx = r_idx;
        endcase
        unique case (i_cmd.wr_sel)
            ADR_IDX_M1: w_wr_idx = w_idx_m1;
            ADR_IDX_P1: w_wr_idx = w_idx_p1;
            default:    w_wr_idx = r_idx;
        endcase
    end

    // element store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_idx[AW-1:0]] <= i_cmd.wr_value ? r_value : r_rdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_idx[AW-1:0]];
        end
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_ZERO:  n_idx = '0;
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = CW'(r_pos);
            IDX_INC:   n_idx = w_idx_p1;
            IDX_DEC:   n_idx = w_idx_m1;
            default:   n_idx = r_idx;
        endcase
        unique case (i_cmd.cnt_op)
            CNT_CLEAR: n_count = '0;
            CNT_INC:   n_count = r_count + CW'(1);
            CNT_DEC:   n_count = r_count - CW'(1);
            default:   n_count = r_count;
        endcase
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_s_tuser);
            r_pos   <= i_s_tdata[POS_W-1:0];
            r_value <= i_s_tdata[POS_W +: VAL_W];
        end
        if (i_cmd.load) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load) begin
            r_elem <= '0;
        end else if (i_cmd.cap_elem) begin
            r_elem <= r_rdata;
        end
        if (i_cmd.load) begin
            r_found <= '0;
        end else if (i_cmd.cap_found) begin
            r_found <= POS_W'(w_idx_p1);
        end
        if (i_cmd.out_load) begin
            r_out_data <= OUT_TDATA_W'({(r_count == '0), LEN_W'(r_count), r_found,
                                        r_elem, r_status});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_flags.kind         = r_kind;
        o_flags.pos_bad_ins  = (w_pos_x == '0) || (w_pos_x > w_cnt_x + EW'(1));
        o_flags.pos_bad      = (w_pos_x == '0) || (w_pos_x > w_cnt_x);
        o_flags.count_zero   = (r_count == '0);
        o_flags.count_one    = (r_count == CW'(1));
        o_flags.count_full   = (r_count == CW'(DEPTH));
        o_flags.idx_ge_pos   = (w_idx_x >= w_pos_x);
        o_flags.idx_lt_count = (r_idx < r_count);
        o_flags.idx_zero     = (r_idx == '0);
        o_flags.idx_last     = (w_idx_p1 == r_count);
        o_flags.match        = (r_rdata == r_value);
        o_flags.out_free     = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");

    // count moves by one or drops to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))
         || (r_count == '0)))
        else $error("count jumped");

    // stores stay inside the occupied part plus one free slot
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> ((w_wr_idx <= r_count) && (r_count < CW'(DEPTH) || w_wr_idx < r_count)))
        else $error("store write outside list");
`endif

endmodule

// ===== design/ple_ctrl.sv =====
// request sequencer of the positional list engine
// depends on ple_pkg; commands ple_datapath through t_cmd and reads its t_flags

module ple_ctrl import ple_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_tvalid,
    output logic   o_s_tready,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_LAST,
        S_FETCH,
        S_CAPTURE,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_NB_CAP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = ADR_IDX;
        o_cmd.wr_en      = 1'b0;
        o_cmd.wr_sel     = ADR_IDX;
        o_cmd.wr_value   = 1'b0;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = ST_OK;
        o_cmd.cap_elem   = 1'b0;
        o_cmd.cap_found  = 1'b0;
        o_cmd.out_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FINISH;
                unique case (i_flags.kind)
                    KIND_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLEAR;
                    end
                    KIND_INSERT: begin
                        if (i_flags.pos_bad_ins) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADPOS;
                        end else if (i_flags.count_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_CHK;
                        end
                    end
                    KIND_DELETE: begin
                        if (i_flags.count_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (i_flags.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADPOS;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_FETCH;
                        end
                    end
                    KIND_GET: begin
                        if (i_flags.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BADPOS;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_FETCH;
                        end
                    end
                    KIND_LOCATE, KIND_PRED, KIND_SUCC: begin
                        if (i_flags.count_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if ((i_flags.kind == KIND_PRED) && i_flags.count_one) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NONEIGHBOR;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INS_CHK: begin
                n_state = i_flags.idx_ge_pos ? S_INS_RD : S_INS_LAST;
            end
            S_INS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADR_IDX_M1;
                n_state      = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ADR_IDX;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_INS_CHK;
            end
            S_INS_LAST: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = ADR_IDX;
                o_cmd.wr_value = 1'b1;
                o_cmd.cnt_op   = CNT_INC;
                n_state        = S_FINISH;
            end
            S_FETCH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADR_IDX_M1;
                n_state      = S_CAPTURE;
            end
            S_CAPTURE: begin
                o_cmd.cap_elem = 1'b1;
                n_state        = (i_flags.kind == KIND_DELETE) ? S_DEL_CHK : S_FINISH;
            end
            S_DEL_CHK: begin
                if (i_flags.idx_lt_count) begin
                    n_state = S_DEL_RD;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_FINISH;
                end
            end
            S_DEL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADR_IDX;
                n_state      = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = ADR_IDX_M1;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_DEL_CHK;
            end
            S_SCAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = ADR_IDX;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_flags.match) begin
                    n_state = S_FINISH;
                    priority if (i_flags.kind == KIND_LOCATE) begin
                        o_cmd.cap_found = 1'b1;
                    end else if (i_flags.kind == KIND_PRED) begin
                        if (i_flags.idx_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NONEIGHBOR;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ADR_IDX_M1;
                            n_state      = S_NB_CAP;
                        end
                    end else begin
                        if (i_flags.idx_last) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NONEIGHBOR;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = ADR_IDX_P1;
                            n_state      = S_NB_CAP;
                        end
                    end
                end else if (i_flags.idx_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOTFOUND;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_SCAN_RD;
                end
            end
            S_NB_CAP: begin
                o_cmd.cap_elem = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (i_flags.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    // a scan read always lands inside the occupied entries
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD) |-> i_flags.idx_lt_count)
        else $error("scan past end of list");
`endif

endmodule

// ===== dv/list_checker_pkg.sv =====
// result predictor and checker for the positional list engine testbench
// depends on ple_pkg for widths, request kinds and status codes

package list_checker_pkg;

    import ple_pkg::*;

    // kind code that the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int unsigned MAX_REPORTS = 10;

    // laid out from the msb down so that it lines up with tdata bits [53:0]
    typedef struct packed {
        logic              is_empty;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  found_position;
        logic [VAL_W-1:0]  element_out;
        t_status           status;
    } list_result_t;

    class list_checker;
        logic [VAL_W-1:0] store [DEPTH_DEF];
        int               count;
        list_result_t     pending_results [$];
        int unsigned      mismatches;
        int unsigned      results_seen;

        function new();
            count        = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // first index holding v, or count when absent
        function int first_index(logic [VAL_W-1:0] v);
            int k;
            for (k = 0; k < count; k++) begin
                if (store[k] == v) begin
                    return k;
                end
            end
            return count;
        endfunction

        // apply one accepted request to the list and queue its result
        function void apply_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                    logic [VAL_W-1:0] value);
            list_result_t r;
            int           p;
            int           idx;
            int           k;
            p                = pos;
            r.status         = ST_OK;
            r.element_out    = '0;
            r.found_position = '0;
            case (kind)
                KIND_CLEAR: begin
                    count = 0;
                end
                KIND_INSERT: begin
                    if (p < 1 || p > count + 1) begin
                        r.status = ST_BADPOS;
                    end else if (count >= DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        for (k = count; k >= p; k--) begin
                            store[k] = store[k-1];
                        end
                        store[p-1] = value;
                        count++;
                    end
                end
                KIND_DELETE: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else if (p < 1 || p > count) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.element_out = store[p-1];
                        for (k = p; k < count; k++) begin
                            store[k-1] = store[k];
                        end
                        count--;
                    end
                end
                KIND_GET: begin
                    if (p < 1 || p > count) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.element_out = store[p-1];
                    end
                end
                KIND_LOCATE: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        idx = first_index(value);
                        if (idx >= count) begin
                            r.status = ST_NOTFOUND;
                        end else begin
                            r.found_position = POS_W'(idx + 1);
                        end
                    end
                end
                KIND_PRED: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else if (count == 1) begin
                        r.status = ST_NONEIGHBOR;
                    end else begin
                        idx = first_index(value);
                        if (idx >= count) begin
                            r.status = ST_NOTFOUND;
                        end else if (idx == 0) begin
                            r.status = ST_NONEIGHBOR;
                        end else begin
                            r.element_out = store[idx-1];
                        end
                    end
                end
                KIND_SUCC: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        idx = first_index(value);
                        if (idx >= count) begin
                            r.status = ST_NOTFOUND;
                        end else if (idx + 1 >= count) begin
                            r.status = ST_NONEIGHBOR;
                        end else begin
                            r.element_out = store[idx+1];
                        end
                    end
                end
                default: ;
            endcase
            r.length   = LEN_W'(count);
            r.is_empty = (count == 0);
            pending_results.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        // compare one result transfer against the oldest queued result
        function void compare_result(logic [OUT_TDATA_W-1:0] data);
            list_result_t got;
            list_result_t want;
            got = list_result_t'(data[$bits(list_result_t)-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %0d with no request outstanding: tdata %h",
                                        results_seen, data));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.element_out !== want.element_out ||
                got.found_position !== want.found_position ||
                got.length !== want.length || got.is_empty !== want.is_empty) begin
                note_mismatch($sformatf(
                    {"result %0d mismatch: status %0d/%0d element %0d/%0d ",
                     "found %0d/%0d length %0d/%0d empty %0b/%0b (expected/actual)"},
                    results_seen, want.status, got.status,
                    $signed(want.element_out), $signed(got.element_out),
                    want.found_position, got.found_position,
                    want.length, got.length, want.is_empty, got.is_empty));
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
// top-level testbench for positional_list_engine: stream drivers, idling and run control
// depends on ple_pkg, list_checker_pkg and the positional_list_engine rtl

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;
    import list_checker_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 8;
    // requests after the directed part, full-list pass included, split over three idling phases
    localparam int RANDOM_ITEMS = 830;
    localparam int PHASE_ITEMS  = 280;
    // long receiver hold-off so the engine fills up and stalls its request side
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 1500;
    // idle time after the drain, longer than the worst single request at full depth
    localparam int DRAIN_CYCLES = 1000;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    list_checker list_chk;
    int          n_sent        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        rx_hold       = 1'b0;
    int          cycle_count   = 0;

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    positional_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // values biased to the extremes and to a small pool, so duplicates show up
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return VAL_W'($urandom_range(7));
            3:       return 32'hffff_fff8 | VAL_W'($urandom_range(7));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // mostly a value already in the list, so searches hit
    function automatic logic [VAL_W-1:0] search_value();
        if (list_chk.count != 0 && $urandom_range(99) < 75) begin
            return list_chk.store[$urandom_range(list_chk.count - 1)];
        end
        return random_value();
    endfunction

    // offer one request after a random gap and wait for its transfer;
    // tvalid stays high when the next request follows straight away
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        // [8:0] position, [40:9] value, upper bits zero
        s_axis_tdata  <= {{(IN_TDATA_W-POS_W-VAL_W){1'b0}}, value, pos};
        do begin
            @(posedge i_clk);
        end while (s_axis_tready !== 1'b1);
        list_chk.apply_request(kind, pos, value);
        n_sent++;
    endtask

    // one random request: mostly in-range positions, some bad ones; the insert
    // and delete mix flips above 40 entries to keep shifts short
    task automatic random_request();
        int                cnt;
        int                sel;
        int                lim;
        int                pos;
        logic [KIND_W-1:0] kind;
        cnt = list_chk.count;
        sel = $urandom_range(99);
        if (sel < 2) begin
            kind = KIND_CLEAR;
        end else if (sel < 3) begin
            kind = KIND_UNUSED;
        end else if (sel < 33) begin
            kind = (cnt > 40) ? KIND_DELETE : KIND_INSERT;
        end else if (sel < 53) begin
            kind = (cnt > 40) ? KIND_INSERT : KIND_DELETE;
        end else if (sel < 68) begin
            kind = KIND_GET;
        end else if (sel < 80) begin
            kind = KIND_LOCATE;
        end else if (sel < 90) begin
            kind = KIND_PRED;
        end else begin
            kind = KIND_SUCC;
        end
        lim = (kind == KIND_INSERT) ? cnt + 1 : cnt;
        if (lim != 0 && $urandom_range(99) < 85) begin
            pos = $urandom_range(lim, 1);
        end else begin
            case ($urandom_range(2))
                0:       pos = 0;
                1:       pos = lim + 1;
                default: pos = $urandom_range(511);
            endcase
        end
        send_request(kind, POS_W'(pos),
                     (kind == KIND_INSERT) ? random_value() : search_value());
    endtask

    // empty-list cases, extreme values, duplicates and every kind on a short list
    task automatic run_directed();
        send_request(KIND_GET,    1, 0);
        send_request(KIND_DELETE, 1, 0);
        send_request(KIND_LOCATE, 0, 0);
        send_request(KIND_PRED,   0, 0);
        send_request(KIND_SUCC,   0, 0);
        send_request(KIND_CLEAR,  0, 0);
        send_request(KIND_INSERT, 0, 5);
        send_request(KIND_INSERT, 2, 5);
        send_request(KIND_INSERT, 1, 32'h8000_0000);
        // single entry: no neighbor without a search
        send_request(KIND_PRED,   0, 32'h8000_0000);
        send_request(KIND_INSERT, 2, 32'h7fff_ffff);
        send_request(KIND_INSERT, 1, 0);
        // duplicate of the head, searches must take the first one
        send_request(KIND_INSERT, 2, 0);
        send_request(KIND_INSERT, 511, 32'hffff_ffff);
        send_request(KIND_LOCATE, 0, 0);
        send_request(KIND_LOCATE, 0, 12345);
        send_request(KIND_PRED,   0, 0);
        send_request(KIND_PRED,   0, 32'h7fff_ffff);
        send_request(KIND_SUCC,   0, 32'h7fff_ffff);
        send_request(KIND_SUCC,   0, 0);
        send_request(KIND_GET,    4, 0);
        send_request(KIND_GET,    0, 0);
        send_request(KIND_DELETE, 5, 0);
        send_request(KIND_DELETE, 2, 0);
        send_request(KIND_UNUSED, 1, 32'hffff_ffff);
        send_request(KIND_CLEAR,  0, 0);
    endtask

    // append up to capacity, then probe the full list at its edges
    task automatic fill_to_capacity();
        send_request(KIND_CLEAR, 0, 0);
        while (list_chk.count < DEPTH_DEF) begin
            send_request(KIND_INSERT, POS_W'(list_chk.count + 1), random_value());
        end
        send_request(KIND_INSERT, 1, random_value());
        send_request(KIND_INSERT, 257, random_value());
        send_request(KIND_INSERT, 258, random_value());
        send_request(KIND_INSERT, 0, random_value());
        send_request(KIND_GET, 256, 0);
        send_request(KIND_GET, 257, 0);
        send_request(KIND_LOCATE, 0, list_chk.store[DEPTH_DEF-1]);
        send_request(KIND_SUCC, 0, list_chk.store[DEPTH_DEF-1]);
        send_request(KIND_PRED, 0, list_chk.store[0]);
        send_request(KIND_DELETE, 256, 0);
        send_request(KIND_DELETE, 1, 0);
        send_request(KIND_INSERT, 1, random_value());
        send_request(KIND_CLEAR, 0, 0);
    endtask

    // result side: check every transfer, then pick next cycle's tready
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                list_chk.compare_result(m_axis_tdata);
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one long receiver stall while requests keep coming
    initial begin
        wait (n_sent >= HOLD_AFTER);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int rand_base;
        list_chk = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        rand_base = n_sent;

        // phase 0: sender idles lightly, receiver heavily
        send_idle_pct <= 35;
        recv_idle_pct <= 68;
        repeat (PHASE_ITEMS) random_request();

        // phase 1: the other way round
        send_idle_pct <= 68;
        recv_idle_pct <= 35;
        repeat (PHASE_ITEMS) random_request();

        // phase 2: back to back, including the full-list pass
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        fill_to_capacity();
        while (n_sent - rand_base < RANDOM_ITEMS) begin
            random_request();
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then watch for stray transfers
        while (list_chk.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (list_chk.mismatches == 0 && list_chk.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ple_pkg.sv
design/ple_datapath.sv
design/ple_ctrl.sv
design/positional_list_engine.sv
dv/list_checker_pkg.sv
dv/tb_top.sv
